// File: sv/vprs_pkg.sv
// ----------------------------------------------------------------------------
// vprs_pkg - shared types and constants for the vertical resize tap engine
// Field layout, register indexes, pixel finishing arithmetic.
// ----------------------------------------------------------------------------
package vprs_pkg;

	localparam int MAX_TAPS   = 64;
	localparam int STORE_AW   = $clog2(MAX_TAPS);

	localparam int TAP_W      = 6;
	localparam int COEFF_W    = 16;
	localparam int SAMPLE_W   = 16;
	localparam int PIX_W      = 16;
	localparam int FWIDTH_W   = 7;
	localparam int ACC_W      = 32;
	localparam int FRAC_BITS  = 14;

	// s_tdata layout, lowest bit first: tap, coeff, sample, zero pad
	localparam int TAP_LSB    = 0;
	localparam int COEFF_LSB  = TAP_LSB + TAP_W;
	localparam int SAMPLE_LSB = COEFF_LSB + COEFF_W;
	localparam int IN_BITS    = SAMPLE_LSB + SAMPLE_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MAX = 1'd1;

	localparam logic [FWIDTH_W-1:0] FWIDTH_RESET = 7'd8;
	localparam logic [PIX_W-1:0]    PMAX_RESET   = 16'hFFFF;

	localparam logic [ACC_W-1:0]   ROUND_BIAS = 32'd1 << (FRAC_BITS - 1);
	localparam logic signed [15:0] SAT_HI     = 16'sh7FFF;
	localparam logic signed [15:0] SAT_LO     = 16'sh8000;

	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	typedef enum logic {
		KIND_COEFF  = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	// width register mapped into 1..MAX_TAPS
	function automatic logic [FWIDTH_W-1:0] eff_width(input logic [FWIDTH_W-1:0] fw);
		logic [FWIDTH_W-1:0] w;
		w = fw;
		if (fw == '0)
			w = FWIDTH_W'(1);
		else if ({1'b0, fw} > (FWIDTH_W+1)'(MAX_TAPS))
			w = FWIDTH_W'(MAX_TAPS);
		return w;
	endfunction

	// round, shift, saturate to int16, clamp top, re-bias to unsigned
	function automatic logic [PIX_W-1:0] finish_pixel(input logic [ACC_W-1:0] acc,
			input logic [PIX_W-1:0] pmax);
		logic [ACC_W-1:0]                  v;
		logic signed [ACC_W-FRAC_BITS-1:0] s;
		logic signed [15:0]                sat;
		logic signed [15:0]                top;
		v = acc + ROUND_BIAS;
		s = signed'(v[ACC_W-1:FRAC_BITS]);
		if (s > (ACC_W-FRAC_BITS)'(SAT_HI))
			sat = SAT_HI;
		else if (s < (ACC_W-FRAC_BITS)'(SAT_LO))
			sat = SAT_LO;
		else
			sat = s[15:0];
		top = signed'({~pmax[15], pmax[14:0]});
		if (sat > top)
			sat = top;
		return {~sat[15], sat[14:0]};
	endfunction

endpackage

// File: sv/vprs_ram.sv
// ----------------------------------------------------------------------------
// vprs_ram - generic single write port RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module vprs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/vertical_polyphase_resize_u16_unit.sv
// ----------------------------------------------------------------------------
// vertical_polyphase_resize_u16_unit - vertical polyphase tap engine, 16-bit
// Coefficient beats fill the tap store; sample beats multiply-accumulate and
// the last tap of a filter produces one rounded, clamped pixel.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tdata: tap, coeff, sample; tuser: kind
//  m_*     | out | m_tvalid/m_tready | tdata: pixel_out
//  cfg_*   | in  | cfg_valid/ready   | cfg_index, cfg_data
//
//  One input beat per cycle while s_tready is high. A pixel's last tap beat
//  passes store read, multiply, accumulate, finish into an 8-entry output queue.
//  s_tready comes from registered queue credits only, so stalls on m_* never
//  reach s_* combinationally; with m_tready high the input never stalls.
//  Reset: arst_n clears control, tap count 8, pixel_max 65535. The tap
//  store is not cleared.
// ----------------------------------------------------------------------------
module vertical_polyphase_resize_u16_unit
	import vprs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [5:0] tap, [21:6] coeff, [37:22] sample
	input  logic                  s_tuser,   // [0] kind

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // [15:0] pixel_out

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [FWIDTH_W-1:0] fwidth_q;
	logic [PIX_W-1:0]    pmax_q;

	logic                in_fire;
	kind_t               in_kind;
	logic [TAP_W-1:0]    in_tap;
	logic [COEFF_W-1:0]  in_coeff;
	logic [SAMPLE_W-1:0] in_sample;
	logic [FWIDTH_W-1:0] w_eff;
	logic                in_use;
	logic                in_last;
	logic                store_we;

	logic                valid_s1, tap0_s1, emit_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [COEFF_W-1:0]  coeff_rd;
	logic signed [15:0]  coeff_sgn, diff_sgn;
	logic signed [31:0]  prod_c;

	logic                valid_s2, tap0_s2, emit_s2;
	logic [ACC_W-1:0]    prod_s2;

	logic [ACC_W-1:0]    acc_q;
	logic                emit_s3;

	logic [PIX_W-1:0]    outq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [OUTQ_AW:0]    cnt_q;
	logic [OUTQ_AW+1:0]  credit_used;
	logic                pop;

	// ---------------- configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwidth_q <= FWIDTH_RESET;
			pmax_q   <= PMAX_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TAP_COUNT: fwidth_q <= cfg_data[FWIDTH_W-1:0];
				REG_PIXEL_MAX: pmax_q   <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input decode
	assign in_fire   = s_tvalid && s_tready;
	assign in_kind   = kind_t'(s_tuser);
	assign in_tap    = s_tdata[TAP_LSB +: TAP_W];
	assign in_coeff  = s_tdata[COEFF_LSB +: COEFF_W];
	assign in_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];
	assign w_eff     = eff_width(fwidth_q);
	assign in_use    = in_fire && (in_kind == KIND_SAMPLE)
		&& ({1'b0, in_tap} < w_eff);
	assign in_last   = ({1'b0, in_tap} == w_eff - FWIDTH_W'(1));
	assign store_we  = in_fire && (in_kind == KIND_COEFF)
		&& ((TAP_W+1)'(in_tap) < (TAP_W+1)'(MAX_TAPS));

	vprs_ram #(
		.WIDTH (COEFF_W),
		.DEPTH (MAX_TAPS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (STORE_AW'(in_tap)),
		.wdata (in_coeff),
		.raddr (STORE_AW'(in_tap)),
		.rdata (coeff_rd)
	);

	// ---------------- stage 1: coefficient arrives, multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			tap0_s1  <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= in_use;
			tap0_s1  <= (in_tap == '0);
			emit_s1  <= in_use && in_last;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= in_sample;
	end

	// sample - 32768 as int16 is the sample with its top bit flipped
	assign coeff_sgn = signed'(coeff_rd);
	assign diff_sgn  = signed'({~sample_s1[15], sample_s1[14:0]});
	assign prod_c    = coeff_sgn * diff_sgn;

	// ---------------- stage 2: accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			tap0_s2  <= 1'b0;
			emit_s2  <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			tap0_s2  <= tap0_s1;
			emit_s2  <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ACC_W'(unsigned'(prod_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			emit_s3 <= 1'b0;
		end else begin
			emit_s3 <= valid_s2 && emit_s2;
			if (valid_s2)
				acc_q <= tap0_s2 ? prod_s2 : acc_q + prod_s2;
		end
	end

	// ---------------- stage 3: finish into output queue
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = outq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (emit_s3)
			outq_q[wr_ptr_q] <= finish_pixel(acc_q, pmax_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (emit_s3)
				wr_ptr_q <= wr_ptr_q + OUTQ_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			case ({emit_s3, pop})
				2'b10:   cnt_q <= cnt_q + (OUTQ_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (OUTQ_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// every pixel still in the pipe holds a queue slot
	assign credit_used = (OUTQ_AW+2)'(cnt_q) + (OUTQ_AW+2)'(emit_s1)
		+ (OUTQ_AW+2)'(emit_s2) + (OUTQ_AW+2)'(emit_s3);
	assign s_tready    = (credit_used < (OUTQ_AW+2)'(OUTQ_DEPTH));

endmodule

// File: sv/vprs_chk.sv
// ----------------------------------------------------------------------------
// vprs_chk - port-level checker for the vertical resize tap engine
// Output hold rules, input stall only behind held output, result latency.
// ----------------------------------------------------------------------------
module vprs_chk
	import vprs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [PIX_W-1:0]      m_tdata
);

	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m_tdata changed while stalled");

	// input only backs up once pixels are waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// an empty output fills only from an earlier accepted sample beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == KIND_SAMPLE), 4))
		else $error("pixel without matching sample beat");

endmodule

bind vertical_polyphase_resize_u16_unit vprs_chk u_vprs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the vertical resize tap engine
// A directed table covers reset state, saturation, clamping, width limits,
// ignored taps and accumulator wrap; random filter passes, noise beats and
// random stalls on both streams follow. Every pixel is checked in order against
// the table or a local model of the multiply-accumulate and finishing arithmetic.
// ----------------------------------------------------------------------------
module testbench;
	import vprs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS    = 31;
	localparam int PHASES      = 10;

	typedef struct packed {
		logic                 is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [15:0]          reg_val;
		kind_t                kind;
		logic [TAP_W-1:0]     tap;
		logic [COEFF_W-1:0]   coeff;
		logic [SAMPLE_W-1:0]  smp;
		logic                 known;
		logic [PIX_W-1:0]     pix;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;     // [5:0] tap, [21:6] coeff, [37:22] sample
	logic                  s_tuser = 1'b0;   // [0] kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [PIX_W-1:0]      m_tdata;          // [15:0] pixel_out
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model state
	logic signed [15:0] tap_coef [MAX_TAPS];
	bit                 coef_valid [MAX_TAPS];
	logic [31:0]        acc_model = '0;
	logic [6:0]         fw_model = 7'd8;
	logic [15:0]        pmax_model = 16'hFFFF;

	logic [PIX_W-1:0]   pending_pixels [$];
	int                 mismatches = 0;
	int                 items_used = 0;
	int                 pixels_queued = 0;
	bit                 src_burst = 1'b0;
	bit                 hold_request = 1'b0;

	plan_row_t          dir_plan [DIR_ROWS];

	vertical_polyphase_resize_u16_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [15:0] v);
		plan_row_t r;
		r = '0;
		r.is_reg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = v;
		return r;
	endfunction

	function automatic plan_row_t beat_row(input kind_t k, input logic [TAP_W-1:0] t,
			input logic [COEFF_W-1:0] c, input logic [SAMPLE_W-1:0] smp);
		plan_row_t r;
		r = '0;
		r.kind  = k;
		r.tap   = t;
		r.coeff = c;
		r.smp   = smp;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [TAP_W-1:0] t,
			input logic [SAMPLE_W-1:0] smp, input logic [PIX_W-1:0] pix);
		plan_row_t r;
		r = beat_row(KIND_SAMPLE, t, '0, smp);
		r.known = 1'b1;
		r.pix   = pix;
		return r;
	endfunction

	function automatic int taps_in_use();
		if (fw_model == '0)
			return 1;
		if (int'(fw_model) > MAX_TAPS)
			return MAX_TAPS;
		return int'(fw_model);
	endfunction

	// one beat through the tap engine; returns 1 when a pixel comes out
	function automatic bit filter_beat(input kind_t k, input logic [TAP_W-1:0] t,
			input logic [COEFF_W-1:0] c, input logic [SAMPLE_W-1:0] smp,
			output logic [PIX_W-1:0] pix);
		int                 prod;
		int                 lvl;
		int                 ceil_lvl;
		logic [31:0]        rounded;
		logic signed [17:0] q;
		pix = '0;
		if (k == KIND_COEFF) begin
			tap_coef[t]   = c;
			coef_valid[t] = 1'b1;
			return 1'b0;
		end
		if (int'(t) >= taps_in_use())
			return 1'b0;
		prod = int'(tap_coef[t]) * (int'({16'd0, smp}) - 32768);
		acc_model = (t == '0) ? prod : acc_model + prod;
		if (int'(t) != taps_in_use() - 1)
			return 1'b0;
		rounded = acc_model + 32'd8192;
		q = rounded[31:14];
		lvl = q;
		if (lvl > 32767)
			lvl = 32767;
		else if (lvl < -32768)
			lvl = -32768;
		ceil_lvl = int'({16'd0, pmax_model}) - 32768;
		if (lvl > ceil_lvl)
			lvl = ceil_lvl;
		pix = 16'(lvl + 32768);
		return 1'b1;
	endfunction

	function automatic int pick_gap(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return SAMPLE_W'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s, expected %0d, got %0d, at %0t", what, want, got, $time);
	endtask

	task automatic send_beat(input kind_t k, input logic [TAP_W-1:0] t,
			input logic [COEFF_W-1:0] c, input logic [SAMPLE_W-1:0] smp,
			input bit known, input logic [PIX_W-1:0] pix);
		int               gap;
		logic [PIX_W-1:0] want;
		gap = pick_gap(src_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= IN_DATA_W'({smp, c, t});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// samples past the filter width are dropped and do not count
		if (!(k == KIND_SAMPLE && int'(t) >= taps_in_use()))
			items_used++;
		if (filter_beat(k, t, c, smp, want)) begin
			pending_pixels.push_back(known ? pix : want);
			pixels_queued++;
		end
	endtask

	// drain: results first, then let dropped beats clear the pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		settle();
		cfg_index <= idx;
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_TAP_COUNT)
			fw_model = v[6:0];
		else
			pmax_model = v;
	endtask

	// full in-order filter pass, optionally reloading the taps first
	task automatic filter_pass();
		int w;
		int j;
		int c;
		bit reload;
		bit smooth;
		w = taps_in_use();
		reload = ($urandom_range(0, 3) == 0);
		for (int t = 0; t < w; t++)
			if (!coef_valid[t])
				reload = 1'b1;
		src_burst = ($urandom_range(0, 3) == 0);
		if (reload) begin
			smooth = ($urandom_range(0, 2) != 0);
			j = 2048 / w + 32;
			for (int t = 0; t < w; t++) begin
				// smooth sets sum to roughly unity gain
				if (smooth)
					c = 16384 / w + int'($urandom_range(0, 2 * j)) - j;
				else
					c = $urandom;
				send_beat(KIND_COEFF, TAP_W'(t), COEFF_W'(c), SAMPLE_W'($urandom), 1'b0, '0);
			end
		end
		for (int t = 0; t < w; t++)
			send_beat(KIND_SAMPLE, TAP_W'(t), COEFF_W'($urandom), pick_sample(), 1'b0, '0);
		src_burst = 1'b0;
	endtask

	task automatic noise_beat();
		logic [TAP_W-1:0] t;
		t = TAP_W'($urandom);
		if ($urandom_range(0, 1) == 0) begin
			send_beat(KIND_COEFF, t, COEFF_W'($urandom), SAMPLE_W'($urandom), 1'b0, '0);
		end else begin
			if (!coef_valid[t])
				send_beat(KIND_COEFF, t, COEFF_W'($urandom), SAMPLE_W'($urandom), 1'b0, '0);
			send_beat(KIND_SAMPLE, t, COEFF_W'($urandom), pick_sample(), 1'b0, '0);
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : pixel_sink
		int               stall_left;
		int               hold_left;
		int               tick;
		bit               burst;
		bit               took;
		logic [PIX_W-1:0] want;
		stall_left = 0;
		hold_left  = 0;
		tick       = 0;
		burst      = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				took = m_tvalid && m_tready;
				if (took) begin
					if (pending_pixels.size() == 0) begin
						report_mismatch("pixel with none pending", 'x, m_tdata);
					end else begin
						want = pending_pixels.pop_front();
						if (m_tdata !== want)
							report_mismatch("pixel_out", want, m_tdata);
					end
				end
				tick++;
				if (tick % 128 == 0)
					burst = ($urandom_range(0, 3) == 0);
				if (hold_request) begin
					hold_request = 1'b0;
					hold_left    = 300;
				end
				if (hold_left > 0) begin
					hold_left--;
					m_tready <= 1'b0;
				end else begin
					if (took)
						stall_left = pick_gap(burst);
					else if (stall_left == 0 && !burst && $urandom_range(0, 15) == 0)
						stall_left = pick_gap(1'b0);
					if (stall_left > 0) begin
						stall_left--;
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			end
		end
	end

	initial begin
		int fw_plan [PHASES];
		int pm_plan [PHASES];
		int start_items;
		int start_pix;
		dir_plan = '{
			// reset state: width 8, accumulator zero, no clamp
			beat_row(KIND_COEFF, 6'd7, 16'h4000, 16'd0),
			known_row(6'd7, 16'd40000, 16'd40000),
			reg_row(REG_TAP_COUNT, 16'd1),
			beat_row(KIND_COEFF, 6'd0, 16'h4000, 16'd0),
			known_row(6'd0, 16'd0, 16'd0),
			known_row(6'd0, 16'd65535, 16'd65535),
			known_row(6'd0, 16'd32768, 16'd32768),
			beat_row(KIND_COEFF, 6'd0, 16'h8000, 16'd0),
			known_row(6'd0, 16'd0, 16'd65535),
			known_row(6'd0, 16'd65535, 16'd0),
			beat_row(KIND_COEFF, 6'd0, 16'h7FFF, 16'd0),
			beat_row(KIND_SAMPLE, 6'd0, 16'h0000, 16'd65535),
			// zero pixel_max pins every pixel at zero
			reg_row(REG_PIXEL_MAX, 16'd0),
			known_row(6'd0, 16'd65535, 16'd0),
			reg_row(REG_PIXEL_MAX, 16'd1023),
			known_row(6'd0, 16'd65535, 16'd1023),
			beat_row(KIND_SAMPLE, 6'd0, 16'h0000, 16'd12345),
			reg_row(REG_PIXEL_MAX, 16'd65535),
			// width 0 behaves as 1, so tap 1 is dropped
			reg_row(REG_TAP_COUNT, 16'd0),
			beat_row(KIND_COEFF, 6'd1, 16'h1234, 16'd0),
			beat_row(KIND_SAMPLE, 6'd0, 16'hFFFF, 16'd40000),
			beat_row(KIND_SAMPLE, 6'd1, 16'h0000, 16'd12345),
			// two full positive products wrap the accumulator, then tap 1 again
			reg_row(REG_TAP_COUNT, 16'd2),
			beat_row(KIND_COEFF, 6'd0, 16'h8000, 16'd0),
			beat_row(KIND_COEFF, 6'd1, 16'h8000, 16'd0),
			beat_row(KIND_SAMPLE, 6'd0, 16'h0000, 16'd0),
			beat_row(KIND_SAMPLE, 6'd1, 16'h0000, 16'd0),
			beat_row(KIND_SAMPLE, 6'd1, 16'h0000, 16'd0),
			// width above the store depth acts as 64; tap 63 alone ends the pixel
			reg_row(REG_TAP_COUNT, 16'd100),
			beat_row(KIND_COEFF, 6'd63, 16'h2000, 16'd0),
			beat_row(KIND_SAMPLE, 6'd63, 16'hFFFF, 16'd65535)
		};
		fw_plan = '{1, 4, 64, 0, 2, 127, 8, 3, 0, 5};
		pm_plan = '{65535, 1, 65535, 0, 4095, 65535, 0, 255, 65535, 32768};
		fw_plan[8] = $urandom_range(1, 16);
		pm_plan[6] = $urandom_range(0, 65535);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i]) begin
			if (dir_plan[i].is_reg)
				write_reg(dir_plan[i].reg_idx, dir_plan[i].reg_val);
			else
				send_beat(dir_plan[i].kind, dir_plan[i].tap, dir_plan[i].coeff,
					dir_plan[i].smp, dir_plan[i].known, dir_plan[i].pix);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_TAP_COUNT, 16'(fw_plan[p]));
			write_reg(REG_PIXEL_MAX, 16'(pm_plan[p]));
			// width 1 gives a pixel per sample: back the output up hard here
			if (p == 0)
				hold_request = 1'b1;
			start_items = items_used;
			start_pix   = pixels_queued;
			while (items_used - start_items < 35 || pixels_queued == start_pix) begin
				if ($urandom_range(0, 9) < 7)
					filter_pass();
				else
					noise_beat();
			end
		end

		settle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/vprs_pkg.sv
sv/vprs_ram.sv
sv/vertical_polyphase_resize_u16_unit.sv
sv/vprs_chk.sv
bench/testbench.sv
